@@ rtl/core/crdc_pkg.sv @@
package crdc_pkg;

  // Field and register widths
  localparam int ANGLE_W      = 16;
  localparam int COUNT_W      = 8;
  localparam int CFG_W        = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_W        = $clog2(MAX_SEGMENTS + 1);  // holds the effective segment count
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);      // segment index and boundary remainder

  // Shared divider geometry
  localparam int DIV_NUM_W = CFG_W + ANGLE_W;
  localparam int DIV_DEN_W = SEG_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
  localparam logic [DIV_NUM_W-1:0] TURN = DIV_NUM_W'(32'h10000);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEG_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DETENT_OFFSET = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFF_GO,
    ST_OFF_WAIT,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_PREP,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

  // Boundary walk: current position and stepping constants
  typedef struct packed {
    logic               fwd;
    logic [IDX_W-1:0]   seg_idx;
    logic [ANGLE_W-1:0] bang;
    logic [IDX_W-1:0]   rem;
    logic [SEG_W-1:0]   n;
    logic [ANGLE_W-1:0] q;
    logic [IDX_W-1:0]   r;
    logic [ANGLE_W-1:0] cp;
    logic [ANGLE_W-1:0] cc;
  } bnd_req_t;

  typedef struct packed {
    logic               advance;
    logic [IDX_W-1:0]   idx;
    logic [ANGLE_W-1:0] bang;
    logic [IDX_W-1:0]   rem;
  } bnd_res_t;

  typedef struct packed {
    logic neg;
    logic pos;
  } sgn_t;

  // Segment count saturated to 2..MAX_SEGMENTS
  function automatic logic [SEG_W-1:0] eff_segs(input logic [CFG_W-1:0] seg);
    logic [SEG_W-1:0] res;
    if (seg < CFG_W'(2)) begin
      res = SEG_W'(2);
    end else if (int'(seg) > MAX_SEGMENTS) begin
      res = SEG_W'(MAX_SEGMENTS);
    end else begin
      res = SEG_W'(seg);
    end
    return res;
  endfunction

  // Sign of the wrapped half-turn difference (to - from)
  function automatic sgn_t wrap_sign(input logic [ANGLE_W-1:0] from,
                                     input logic [ANGLE_W-1:0] to);
    logic [ANGLE_W-1:0] diff;
    sgn_t               res;
    diff = to - from;
    if (diff == '0) begin
      res.neg = 1'b0;
    end else if (diff == {1'b1, {(ANGLE_W-1){1'b0}}}) begin
      // exactly half a turn apart: negative when to is above from, against the unwrapped order
      res.neg = (to > from);
    end else begin
      res.neg = diff[ANGLE_W-1];
    end
    res.pos = (diff != '0) && !res.neg;
    return res;
  endfunction

endpackage

@@ rtl/core/crdc_div.sv @@
module crdc_div (
  input  logic              clk,
  input  logic              rst,
  input  crdc_pkg::div_req_t req,
  output crdc_pkg::div_rsp_t rsp
);

  logic                           busy;
  logic                           done;
  logic [crdc_pkg::DIV_CNT_W-1:0] cnt;
  logic [crdc_pkg::DIV_NUM_W-1:0] quo;
  logic [crdc_pkg::DIV_DEN_W-1:0] acc;
  logic [crdc_pkg::DIV_DEN_W-1:0] dvs;
  logic [crdc_pkg::DIV_DEN_W:0]   trial;
  logic                           fits;

  // One restoring step: bring down the next numerator bit
  assign trial = {acc, quo[crdc_pkg::DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == crdc_pkg::DIV_CNT_W'(crdc_pkg::DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where the numerator shifts out
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      acc <= '0;
      dvs <= req.den;
    end else if (busy) begin
      if (fits) begin
        acc <= crdc_pkg::DIV_DEN_W'(trial - {1'b0, dvs});
      end else begin
        acc <= trial[crdc_pkg::DIV_DEN_W-1:0];
      end
      quo <= {quo[crdc_pkg::DIV_NUM_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = acc;

endmodule

@@ rtl/core/crdc_bnd.sv @@
module crdc_bnd (
  input  crdc_pkg::bnd_req_t req,
  output crdc_pkg::bnd_res_t res
);

  logic [crdc_pkg::SEG_W-1:0]   n_m1;
  logic                         last;
  logic                         first;
  logic [crdc_pkg::SEG_W-1:0]   sum_r;
  logic                         carry;
  logic [crdc_pkg::SEG_W-1:0]   diff_r;
  logic                         borrow;
  logic [crdc_pkg::IDX_W-1:0]   f_rem;
  logic [crdc_pkg::ANGLE_W-1:0] f_bang;
  logic [crdc_pkg::IDX_W-1:0]   b_rem;
  logic [crdc_pkg::ANGLE_W-1:0] b_bang;
  logic [crdc_pkg::ANGLE_W-1:0] w_bang;
  logic [crdc_pkg::IDX_W-1:0]   w_rem;
  logic [crdc_pkg::IDX_W-1:0]   c_idx;
  logic [crdc_pkg::ANGLE_W-1:0] c_bang;
  logic [crdc_pkg::IDX_W-1:0]   c_rem;
  crdc_pkg::sgn_t               sa;
  crdc_pkg::sgn_t               sb;

  assign n_m1  = req.n - 1'b1;
  assign last  = {1'b0, req.seg_idx} == n_m1;
  assign first = req.seg_idx == '0;

  // Forward: bang += q, remainder += r with one wrap correction
  assign sum_r  = {1'b0, req.rem} + {1'b0, req.r};
  assign carry  = sum_r >= req.n;
  assign f_rem  = carry ? crdc_pkg::IDX_W'(sum_r - req.n) : sum_r[crdc_pkg::IDX_W-1:0];
  assign f_bang = req.bang + req.q + crdc_pkg::ANGLE_W'(carry);

  // Backward: bang -= q, remainder -= r with one borrow correction
  assign diff_r = {1'b0, req.rem} - {1'b0, req.r};
  assign borrow = diff_r[crdc_pkg::SEG_W-1];
  assign b_rem  = borrow ? crdc_pkg::IDX_W'(diff_r + req.n)
                         : diff_r[crdc_pkg::IDX_W-1:0];
  assign b_bang = req.bang - req.q - crdc_pkg::ANGLE_W'(borrow);

  // Backward wrap from segment zero to the last boundary
  assign w_bang = crdc_pkg::ANGLE_W'(17'h10000 - {1'b0, req.q} - 17'(req.r != '0));
  assign w_rem  = (req.r != '0) ? crdc_pkg::IDX_W'(req.n - {1'b0, req.r}) : '0;

  // Candidate boundary
  always_comb begin
    if (req.fwd) begin
      if (last) begin
        c_idx  = '0;
        c_bang = '0;
        c_rem  = '0;
      end else begin
        c_idx  = req.seg_idx + 1'b1;
        c_bang = f_bang;
        c_rem  = f_rem;
      end
    end else begin
      if (first) begin
        c_idx  = n_m1[crdc_pkg::IDX_W-1:0];
        c_bang = w_bang;
        c_rem  = w_rem;
      end else begin
        c_idx  = req.seg_idx - 1'b1;
        c_bang = b_bang;
        c_rem  = b_rem;
      end
    end
  end

  assign res.idx  = c_idx;
  assign res.bang = c_bang;
  assign res.rem  = c_rem;

  // Boundary must lie between the shifted old and new angles
  assign sa = crdc_pkg::wrap_sign(req.cp, c_bang);
  assign sb = crdc_pkg::wrap_sign(c_bang, req.cc);
  assign res.advance = req.fwd ? !(sa.neg || sb.neg) : !(sa.pos || sb.pos);

endmodule

@@ rtl/core/crank_detent_click_counter.sv @@
// An accepted beat goes from IDLE through PREP and WALK, which crosses k boundaries, to
// DONE and its click beat (a zero step goes straight to DONE); k is at most the effective
// segment count (2..64). After reset or a configuration write the next nonzero step first
// runs two passes of the shared divider (offset and boundary pitch).
// A new beat is taken only in IDLE, once the previous click is in the output register.
// Reset: synchronous; seg_count = 8, detent_offset = 0, angle and segment cleared.
module crank_detent_click_counter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               angle_valid,
  output logic                               angle_ready,
  input  logic signed [crdc_pkg::ANGLE_W-1:0] angle_delta,
  output logic                               click_valid,
  input  logic                               click_ready,
  output logic signed [crdc_pkg::COUNT_W-1:0] click_count,
  input  logic                               cfg_wr_en,
  input  logic [crdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crdc_pkg::CFG_W-1:0]         cfg_data
);

  crdc_pkg::state_t state;
  crdc_pkg::state_t state_next;

  logic [crdc_pkg::CFG_W-1:0]   seg_count;
  logic [crdc_pkg::CFG_W-1:0]   detent_offset;
  logic [crdc_pkg::SEG_W-1:0]   n_eff;
  logic [crdc_pkg::ANGLE_W-1:0] accum_angle;
  logic [crdc_pkg::IDX_W-1:0]   segment_index;
  logic [crdc_pkg::ANGLE_W-1:0] seg_bang;
  logic [crdc_pkg::IDX_W-1:0]   seg_rem;
  logic                         off_ok;
  logic [crdc_pkg::ANGLE_W-1:0] off_angle;
  logic [crdc_pkg::ANGLE_W-1:0] pitch_q;
  logic [crdc_pkg::IDX_W-1:0]   pitch_r;
  logic [crdc_pkg::ANGLE_W-1:0] prev_angle;
  logic [crdc_pkg::ANGLE_W-1:0] cp;
  logic [crdc_pkg::ANGLE_W-1:0] cc;
  logic                         fwd;
  logic [crdc_pkg::SEG_W-1:0]   steps;
  logic [crdc_pkg::COUNT_W-1:0] count;
  logic                         in_beat;
  logic                         out_free;
  logic                         walk_end;
  logic                         cfg_hit;

  crdc_pkg::div_req_t div_req;
  crdc_pkg::div_rsp_t div_rsp;
  crdc_pkg::bnd_req_t bnd_req;
  crdc_pkg::bnd_res_t bnd_res;

  assign n_eff    = crdc_pkg::eff_segs(seg_count);
  assign in_beat  = angle_valid && angle_ready;
  assign out_free = !click_valid || click_ready;
  assign walk_end = (steps == n_eff) || !bnd_res.advance;
  assign cfg_hit  = cfg_wr_en && ((cfg_index == crdc_pkg::REG_SEG_COUNT) ||
                                  (cfg_index == crdc_pkg::REG_DETENT_OFFSET));

  // Shared divider: detent offset and boundary pitch
  crdc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Next boundary in the direction of motion
  assign bnd_req.fwd     = fwd;
  assign bnd_req.seg_idx = segment_index;
  assign bnd_req.bang    = seg_bang;
  assign bnd_req.rem     = seg_rem;
  assign bnd_req.n       = n_eff;
  assign bnd_req.q       = pitch_q;
  assign bnd_req.r       = pitch_r;
  assign bnd_req.cp      = cp;
  assign bnd_req.cc      = cc;

  crdc_bnd u_bnd (
    .req (bnd_req),
    .res (bnd_res)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crdc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer
  always_comb begin
    state_next  = state;
    angle_ready = 1'b0;
    div_req     = '0;
    unique case (state)
      crdc_pkg::ST_IDLE: begin
        angle_ready = 1'b1;
        if (angle_valid) begin
          if (angle_delta == '0) begin
            state_next = crdc_pkg::ST_DONE;
          end else if (!off_ok) begin
            state_next = crdc_pkg::ST_OFF_GO;
          end else begin
            state_next = crdc_pkg::ST_PREP;
          end
        end
      end
      crdc_pkg::ST_OFF_GO: begin
        div_req.start = 1'b1;
        div_req.num   = {detent_offset, {crdc_pkg::ANGLE_W{1'b0}}};
        div_req.den   = {n_eff, 1'b0};
        state_next    = crdc_pkg::ST_OFF_WAIT;
      end
      crdc_pkg::ST_OFF_WAIT: begin
        if (div_rsp.done) begin
          state_next = crdc_pkg::ST_STEP_GO;
        end
      end
      crdc_pkg::ST_STEP_GO: begin
        div_req.start = 1'b1;
        div_req.num   = crdc_pkg::TURN;
        div_req.den   = {1'b0, n_eff};
        state_next    = crdc_pkg::ST_STEP_WAIT;
      end
      crdc_pkg::ST_STEP_WAIT: begin
        if (div_rsp.done) begin
          state_next = crdc_pkg::ST_PREP;
        end
      end
      crdc_pkg::ST_PREP: begin
        state_next = crdc_pkg::ST_WALK;
      end
      crdc_pkg::ST_WALK: begin
        if (walk_end) begin
          state_next = crdc_pkg::ST_DONE;
        end
      end
      crdc_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = crdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = crdc_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count     <= crdc_pkg::CFG_W'(8);
      detent_offset <= '0;
      accum_angle   <= '0;
      segment_index <= '0;
      seg_bang      <= '0;
      seg_rem       <= '0;
      off_ok        <= 1'b0;
    end else if (cfg_hit) begin
      if (cfg_index == crdc_pkg::REG_SEG_COUNT) begin
        seg_count <= cfg_data;
      end else begin
        detent_offset <= cfg_data;
      end
      accum_angle   <= '0;
      segment_index <= '0;
      seg_bang      <= '0;
      seg_rem       <= '0;
      off_ok        <= 1'b0;
    end else begin
      if (in_beat) begin
        accum_angle <= accum_angle + angle_delta;
      end
      if (state == crdc_pkg::ST_STEP_WAIT && div_rsp.done) begin
        off_ok <= 1'b1;
      end
      if (state == crdc_pkg::ST_WALK && !walk_end) begin
        segment_index <= bnd_res.idx;
        seg_bang      <= bnd_res.bang;
        seg_rem       <= bnd_res.rem;
      end
    end
  end

  // Per-beat working registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      prev_angle <= accum_angle;
      fwd        <= !angle_delta[crdc_pkg::ANGLE_W-1];
      steps      <= '0;
      count      <= '0;
    end
    if (state == crdc_pkg::ST_OFF_WAIT && div_rsp.done) begin
      off_angle <= div_rsp.quot[crdc_pkg::ANGLE_W-1:0];
    end
    if (state == crdc_pkg::ST_STEP_WAIT && div_rsp.done) begin
      pitch_q <= div_rsp.quot[crdc_pkg::ANGLE_W-1:0];
      pitch_r <= div_rsp.rem[crdc_pkg::IDX_W-1:0];
    end
    if (state == crdc_pkg::ST_PREP) begin
      cp <= prev_angle + off_angle;
      cc <= accum_angle + off_angle;
    end
    if (state == crdc_pkg::ST_WALK && !walk_end) begin
      steps <= steps + 1'b1;
      count <= fwd ? count + 1'b1 : count - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      click_valid <= 1'b0;
    end else if (state == crdc_pkg::ST_DONE && out_free) begin
      click_valid <= 1'b1;
    end else if (click_ready) begin
      click_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == crdc_pkg::ST_DONE && out_free) begin
      click_count <= count;
    end
  end

`ifndef SYNTHESIS
  // Segment index stays inside the effective segment count
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, segment_index} < n_eff)
    else $error("segment index out of range");

  // Walk never exceeds one full turn of boundaries
  a_steps_cap: assert property (@(posedge clk) disable iff (rst)
    state == crdc_pkg::ST_WALK |-> steps <= n_eff)
    else $error("boundary walk ran past its cap");

  // Divider completes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == crdc_pkg::ST_OFF_WAIT || state == crdc_pkg::ST_STEP_WAIT))
    else $error("divider result with no one waiting");

  // A zero step leaves the angle alone
  a_zero_hold: assert property (@(posedge clk) disable iff (rst)
    (in_beat && angle_delta == '0 && !cfg_hit) |=> $stable(accum_angle))
    else $error("zero step moved the angle");

  // Click magnitude is bounded by the segment count
  a_click_bound: assert property (@(posedge clk) disable iff (rst)
    click_valid |-> ($signed(click_count) <= $signed({1'b0, n_eff}) &&
                     $signed(-click_count) <= $signed({1'b0, n_eff})))
    else $error("click count beyond segment count");
`endif

endmodule

@@ bench/tb_crank_detent_click_counter.sv @@
module tb_crank_detent_click_counter;
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes past the two real registers: writes there must be ignored
  localparam logic [crdc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [crdc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Predicts click counts from crank steps and checks them in order
  class click_tracker;
    logic [crdc_pkg::CFG_W-1:0]          seg_reg;
    logic [crdc_pkg::CFG_W-1:0]          off_reg;
    logic [crdc_pkg::ANGLE_W-1:0]        angle;
    int                                  seg_pos;
    logic signed [crdc_pkg::COUNT_W-1:0] clicks_due[$];
    int                                  errors;

    function new();
      seg_reg = crdc_pkg::CFG_W'(8);
      off_reg = '0;
      angle   = '0;
      seg_pos = 0;
      errors  = 0;
    endfunction

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return clicks_due.size();
    endfunction

    function int seg_total();
      if (seg_reg < 2) return 2;
      if (seg_reg > crdc_pkg::MAX_SEGMENTS) return crdc_pkg::MAX_SEGMENTS;
      return int'(seg_reg);
    endfunction

    // Difference to - from folded into one half-turn either way
    function int half_turn_diff(int from, int to);
      int d;
      d = to - from;
      if (d <= -32768) return d + 65536;
      if (d >= 32768) return d - 65536;
      return d;
    endfunction

    // Register write: real registers also clear angle and segment
    function void write_reg(logic [crdc_pkg::CFG_IDX_W-1:0] idx,
                            logic [crdc_pkg::CFG_W-1:0] val);
      if (idx == crdc_pkg::REG_SEG_COUNT) seg_reg = val;
      else if (idx == crdc_pkg::REG_DETENT_OFFSET) off_reg = val;
      else return;
      angle   = '0;
      seg_pos = 0;
    endfunction

    // Accepted step: advance the angle and walk the boundaries crossed
    function void note_step(logic [crdc_pkg::ANGLE_W-1:0] raw);
      int                           n, off, dir, cnt, nxt, bnd, da, db;
      logic [crdc_pkg::ANGLE_W-1:0] cp, cc, shift;
      if (raw == '0) begin
        clicks_due.push_back('0);
        return;
      end
      n     = seg_total();
      off   = (int'(off_reg) * 65536) / (2 * n);
      shift = off[crdc_pkg::ANGLE_W-1:0];
      cp    = angle + shift;
      angle = angle + raw;
      cc    = angle + shift;
      dir   = raw[crdc_pkg::ANGLE_W-1] ? -1 : 1;
      if (seg_pos >= n) seg_pos = 0;
      cnt = 0;
      for (int s = 0; s < n; s++) begin
        nxt = (dir > 0) ? (seg_pos + 1) % n : (seg_pos + n - 1) % n;
        bnd = (nxt * 65536) / n;
        da  = half_turn_diff(int'(cp), bnd);
        db  = half_turn_diff(bnd, int'(cc));
        if (dir * da < 0 || dir * db < 0) break;
        seg_pos = nxt;
        cnt += dir;
      end
      clicks_due.push_back(cnt[crdc_pkg::COUNT_W-1:0]);
    endfunction

    task check_click(logic signed [crdc_pkg::COUNT_W-1:0] got);
      logic signed [crdc_pkg::COUNT_W-1:0] want;
      if (clicks_due.size() == 0) begin
        report_mismatch($sformatf("click beat %0d with nothing expected", got));
        return;
      end
      want = clicks_due.pop_front();
      if (got !== want)
        report_mismatch($sformatf("click_count got %0d want %0d", got, want));
    endtask
  endclass

  logic                                clk;
  logic                                rst;
  logic                                angle_valid;
  logic                                angle_ready;
  logic signed [crdc_pkg::ANGLE_W-1:0] angle_delta;
  logic                                click_valid;
  logic                                click_ready;
  logic signed [crdc_pkg::COUNT_W-1:0] click_count;
  logic                                cfg_wr_en;
  logic [crdc_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [crdc_pkg::CFG_W-1:0]          cfg_data;

  click_tracker tracker = new();
  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_left     = 0;

  // Directed steps under the reset setting: zero, unit, extremes, one segment
  localparam logic [crdc_pkg::ANGLE_W-1:0] EDGE_STEPS [9] = '{
    16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
    16'h2000, 16'hE000, 16'h1FFF, 16'h0000
  };
  // Directed steps at 64 segments with the largest offset
  localparam logic [crdc_pkg::ANGLE_W-1:0] FINE_STEPS [5] = '{
    16'h0400, 16'hFC00, 16'h7FFF, 16'h8000, 16'h0001
  };

  crank_detent_click_counter dut (
    .clk         (clk),
    .rst         (rst),
    .angle_valid (angle_valid),
    .angle_ready (angle_ready),
    .angle_delta (angle_delta),
    .click_valid (click_valid),
    .click_ready (click_ready),
    .click_count (click_count),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Beat monitors
  always @(posedge clk) begin
    if (!rst && angle_valid && angle_ready) tracker.note_step(angle_delta);
    if (!rst && click_valid && click_ready) tracker.check_click(click_count);
  end

  // Click receiver: random stalls, or a long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        click_ready <= 1'b0;
      end else begin
        click_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat
  task send_step(input logic [crdc_pkg::ANGLE_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      angle_valid <= 1'b0;
      angle_delta <= crdc_pkg::ANGLE_W'($urandom);
      @(negedge clk);
    end
    angle_valid <= 1'b1;
    angle_delta <= d;
    @(posedge clk);
    while (!angle_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait for every click to come back
  task drain();
    angle_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
    repeat (8) @(negedge clk);
  endtask

  task write_reg(input logic [crdc_pkg::CFG_IDX_W-1:0] idx,
                 input logic [crdc_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    tracker.write_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly small and medium moves, some full range, extremes and zero
  function automatic logic [crdc_pkg::ANGLE_W-1:0] pick_step();
    int v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = ($urandom_range(1)) ? 32'h7FFF : 32'h8000;
      2, 3: v = $urandom;
      4, 5: v = int'($urandom_range(24000)) - 12000;
      default: v = int'($urandom_range(6000)) - 3000;
    endcase
    return v[crdc_pkg::ANGLE_W-1:0];
  endfunction

  task random_config();
    logic [crdc_pkg::CFG_W-1:0] seg, off;
    case ($urandom_range(7))
      0: seg = crdc_pkg::CFG_W'($urandom_range(1));
      1: seg = crdc_pkg::CFG_W'($urandom_range(127, 65));
      2: seg = crdc_pkg::CFG_W'(2);
      3: seg = crdc_pkg::CFG_W'(64);
      default: seg = crdc_pkg::CFG_W'($urandom_range(64, 2));
    endcase
    case ($urandom_range(5))
      0: off = '0;
      1: off = crdc_pkg::CFG_W'(127);
      default: off = crdc_pkg::CFG_W'($urandom_range(127));
    endcase
    if ($urandom_range(3) == 0) write_reg(REG_SPARE_A, crdc_pkg::CFG_W'($urandom));
    if ($urandom_range(3) != 0) write_reg(crdc_pkg::REG_SEG_COUNT, seg);
    if ($urandom_range(3) != 0) write_reg(crdc_pkg::REG_DETENT_OFFSET, off);
    if ($urandom_range(3) == 0) write_reg(REG_SPARE_B, crdc_pkg::CFG_W'($urandom));
  endtask

  // Stimulus
  initial begin
    rst         = 1'b1;
    angle_valid = 1'b0;
    angle_delta = '0;
    click_ready = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset setting
    foreach (EDGE_STEPS[i]) send_step(EDGE_STEPS[i]);
    drain();

    // Directed: most segments, largest offset
    write_reg(crdc_pkg::REG_SEG_COUNT, crdc_pkg::CFG_W'(64));
    write_reg(crdc_pkg::REG_DETENT_OFFSET, crdc_pkg::CFG_W'(127));
    foreach (FINE_STEPS[i]) send_step(FINE_STEPS[i]);
    drain();

    // Directed: count of zero saturates up to two, quarter-turn offset
    write_reg(crdc_pkg::REG_SEG_COUNT, '0);
    write_reg(crdc_pkg::REG_DETENT_OFFSET, crdc_pkg::CFG_W'(1));
    send_step(16'h7FFF);
    send_step(16'h7FFF);
    send_step(16'h8000);
    drain();

    // Spare indexes leave registers and state alone
    write_reg(REG_SPARE_A, crdc_pkg::CFG_W'(127));
    write_reg(REG_SPARE_B, '0);
    send_step(16'h4000);
    drain();

    // Count above the maximum saturates down, then a count of one
    write_reg(crdc_pkg::REG_SEG_COUNT, crdc_pkg::CFG_W'(127));
    send_step(16'h7FFF);
    send_step(16'h8001);
    drain();
    write_reg(crdc_pkg::REG_SEG_COUNT, crdc_pkg::CFG_W'(1));
    send_step(16'h8001);
    drain();

    // Random phases under different idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; rcv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rcv_stall_pct = 61; end
        default: begin send_idle_pct = 32; rcv_stall_pct = 32; end
      endcase
      for (int st = 0; st < 4; st++) begin
        random_config();
        // long receiver hold-off so the input side backs up
        if (ph == 0 && st == 1) hold_left = 400;
        for (int k = 0; k < 50; k++) send_step(pick_step());
        drain();
      end
    end

    repeat (70) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
